[hdl/axis_angle_vector_rotate_assert.svh]
// Assertion macros for the axis-angle vector rotator.
`ifndef AXIS_ANGLE_VECTOR_ROTATE_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_ASSERT_SVH

// Checked only while out of reset.
`define AAVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define AAVR_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/aavr_pkg.sv]
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared widths, constants and types of the axis-angle vector rotator.
// ----------------------------------------------------------------------------
`default_nettype none
package aavr_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int DATA_BITS    = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int CW           = 34;   // CORDIC datapath width
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic signed [15:0]          ax;
    logic signed [15:0]          ay;
    logic signed [15:0]          az;
    logic signed [DATA_BITS-1:0] vx;
    logic signed [DATA_BITS-1:0] vy;
    logic signed [DATA_BITS-1:0] vz;
  } aavr_item_t;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'h20000000;  1:  a = 32'h12E4051E;  2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;  4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;  8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;  10: a = 32'h000A2F98;  11: a = 32'h000517CC;
      12: a = 32'h00028BE6;  13: a = 32'h000145F3;  14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;  16: a = 32'h000028BE;  17: a = 32'h0000145F;
      18: a = 32'h00000A2F;  default: a = 32'h00000517;
    endcase
    return $signed({2'b00, a});
  endfunction

endpackage
`default_nettype wire

[hdl/axis_angle_vector_rotate.sv]
// Pipeline from an accepted input beat to its result beat:
// 21 CORDIC stages, one round/clamp stage, five matrix and product stages.
// Throughput: one beat per cycle; the whole pipeline holds while out_stall
// blocks a waiting result.
// Reset: synchronous rst_n clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// Rotates a vector about a unit axis by a binary angle (Rodrigues form).
// ----------------------------------------------------------------------------
`default_nettype none
module axis_angle_vector_rotate (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [15:0]                      in_angle,
  input  wire logic signed [15:0]               in_axis_x,
  input  wire logic signed [15:0]               in_axis_y,
  input  wire logic signed [15:0]               in_axis_z,
  input  wire logic signed [aavr_pkg::DATA_BITS-1:0] in_vec_x,
  input  wire logic signed [aavr_pkg::DATA_BITS-1:0] in_vec_y,
  input  wire logic signed [aavr_pkg::DATA_BITS-1:0] in_vec_z,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [aavr_pkg::DATA_BITS-1:0] out_rot_x,
  output logic signed [aavr_pkg::DATA_BITS-1:0] out_rot_y,
  output logic signed [aavr_pkg::DATA_BITS-1:0] out_rot_z
);
  import aavr_pkg::*;

  localparam int DW = DATA_BITS;
  localparam int MW = 21;              // rounded matrix entry
  localparam int PW = DW + MW;         // vector * entry
  localparam int AW = PW + 2;          // sum of three
  localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (DW-1)) - 1);
  localparam logic signed [AW-1:0] LO = -HI - AW'(1);

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  aavr_item_t in_item, c_item;
  logic c_v;
  logic signed [15:0] c_q, s_q;

  assign in_item = '{ax: in_axis_x, ay: in_axis_y, az: in_axis_z,
                     vx: in_vec_x, vy: in_vec_y, vz: in_vec_z};

  aavr_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid), .angle(in_angle),
    .in_item(in_item), .out_v(c_v), .cos_q(c_q), .sin_q(s_q), .out_item(c_item)
  );

  // Stage 1: axis products
  logic v1_r;
  logic signed [31:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, sx_r, sy_r, sz_r;
  logic signed [15:0] c1_r;
  logic signed [16:0] t1_r;
  logic signed [DW-1:0] vx1_r, vy1_r, vz1_r;

  // Stage 2: times t
  logic v2_r;
  logic signed [47:0] qxx_r, qyy_r, qzz_r, qxy_r, qxz_r, qyz_r;
  logic signed [31:0] sx2_r, sy2_r, sz2_r;
  logic signed [15:0] c2_r;
  logic signed [DW-1:0] vx2_r, vy2_r, vz2_r;

  // Stage 3: matrix entries, rounded to Q.14
  logic v3_r;
  logic signed [MW-1:0] m_r [0:8];
  logic signed [DW-1:0] vx3_r, vy3_r, vz3_r;
  logic signed [47:0] m_full [0:8];
  logic signed [47:0] cu, ssx, ssy, ssz;

  // Stage 4: vector times entries
  logic v4_r;
  logic signed [PW-1:0] p_r [0:8];

  // Stage 5: output
  logic v5_r;
  logic signed [DW-1:0] rx_r, ry_r, rz_r;

  assign cu  = 48'(c2_r) <<< 28;
  assign ssx = 48'(sx2_r) <<< 14;
  assign ssy = 48'(sy2_r) <<< 14;
  assign ssz = 48'(sz2_r) <<< 14;

  always_comb begin
    m_full[0] = cu + qxx_r;
    m_full[1] = qxy_r - ssz;
    m_full[2] = qxz_r + ssy;
    m_full[3] = qxy_r + ssz;
    m_full[4] = cu + qyy_r;
    m_full[5] = qyz_r - ssx;
    m_full[6] = qxz_r - ssy;
    m_full[7] = qyz_r + ssx;
    m_full[8] = cu + qzz_r;
  end

  function automatic logic signed [DW-1:0] fin(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    r = (a + AW'(8192)) >>> 14;
    if (r > HI) r = HI;
    if (r < LO) r = LO;
    return r[DW-1:0];
  endfunction

  logic signed [AW-1:0] sx_sum, sy_sum, sz_sum;
  assign sx_sum = AW'(p_r[0]) + AW'(p_r[1]) + AW'(p_r[2]);
  assign sy_sum = AW'(p_r[3]) + AW'(p_r[4]) + AW'(p_r[5]);
  assign sz_sum = AW'(p_r[6]) + AW'(p_r[7]) + AW'(p_r[8]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= c_v; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
    if (en) begin
      xx_r <= c_item.ax * c_item.ax;  yy_r <= c_item.ay * c_item.ay;
      zz_r <= c_item.az * c_item.az;  xy_r <= c_item.ax * c_item.ay;
      xz_r <= c_item.ax * c_item.az;  yz_r <= c_item.ay * c_item.az;
      sx_r <= s_q * c_item.ax;  sy_r <= s_q * c_item.ay;  sz_r <= s_q * c_item.az;
      c1_r <= c_q;
      t1_r <= 17'(ONE_Q14) - 17'(c_q);
      vx1_r <= c_item.vx; vy1_r <= c_item.vy; vz1_r <= c_item.vz;

      qxx_r <= 48'(xx_r) * 48'(t1_r);  qyy_r <= 48'(yy_r) * 48'(t1_r);
      qzz_r <= 48'(zz_r) * 48'(t1_r);  qxy_r <= 48'(xy_r) * 48'(t1_r);
      qxz_r <= 48'(xz_r) * 48'(t1_r);  qyz_r <= 48'(yz_r) * 48'(t1_r);
      sx2_r <= sx_r; sy2_r <= sy_r; sz2_r <= sz_r;
      c2_r  <= c1_r;
      vx2_r <= vx1_r; vy2_r <= vy1_r; vz2_r <= vz1_r;

      for (int k = 0; k < 9; k++) begin
        m_r[k] <= MW'((m_full[k] + 48'sd134217728) >>> 28);
      end
      vx3_r <= vx2_r; vy3_r <= vy2_r; vz3_r <= vz2_r;

      for (int k = 0; k < 3; k++) begin
        p_r[3*k]   <= PW'(vx3_r) * PW'(m_r[3*k]);
        p_r[3*k+1] <= PW'(vy3_r) * PW'(m_r[3*k+1]);
        p_r[3*k+2] <= PW'(vz3_r) * PW'(m_r[3*k+2]);
      end

      rx_r <= fin(sx_sum);
      ry_r <= fin(sy_sum);
      rz_r <= fin(sz_sum);
    end
  end

  assign out_valid = v5_r;
  assign out_rot_x = rx_r;
  assign out_rot_y = ry_r;
  assign out_rot_z = rz_r;

  `include "axis_angle_vector_rotate_assert.svh"
  `AAVR_ASSERT(a_rst_clear, $past(!rst_n) |-> !out_valid, "valid after reset")
  `AAVR_ASSERT(a_bubble, (en && !v4_r) |=> !out_valid, "result from empty stage")
  `AAVR_ASSERT(a_feed, (en && v4_r) |=> out_valid, "result lost in last stage")
endmodule
`default_nettype wire

[hdl/aavr_cordic.sv]
// ----------------------------------------------------------------------------
// aavr_cordic
// Pipelined rotation CORDIC: one stage per step, then round and clamp to Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none
module aavr_cordic (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_v,
  input  wire logic [15:0]             angle,
  input  wire aavr_pkg::aavr_item_t    in_item,
  output logic                         out_v,
  output logic signed [15:0]           cos_q,
  output logic signed [15:0]           sin_q,
  output aavr_pkg::aavr_item_t         out_item
);
  import aavr_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic signed [CW-1:0] z_r [0:N];
  logic                 neg_r [0:N];
  logic                 v_r   [0:N];
  aavr_item_t           it_r  [0:N];

  logic [31:0]          ph;
  logic                 ph_neg;

  assign ph     = {angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  assign ph_neg = ph[31] ^ ph[30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
    if (en) begin
      x_r[0]   <= CORDIC_X0;
      y_r[0]   <= '0;
      // fold the left half-turn onto the right one
      z_r[0]   <= CW'($signed({ph[31] ^ ph_neg, ph[30:0]}));
      neg_r[0] <= ph_neg;
      it_r[0]  <= in_item;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(i);
        end
        neg_r[i+1] <= neg_r[i];
        it_r[i+1]  <= it_r[i];
      end
    end
  end

  function automatic logic signed [15:0] fin(input logic signed [CW-1:0] a, input logic n);
    logic signed [CW-1:0] r;
    r = (a + CW'(32768)) >>> 16;
    if (n) r = -r;
    if (r > CW'(16384)) return ONE_Q14;
    if (r < -CW'(16384)) return -ONE_Q14;
    return r[15:0];
  endfunction

  logic                 out_v_r;
  logic signed [15:0]   cos_r, sin_r;
  aavr_item_t           item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[N];
    end
    if (en) begin
      cos_r  <= fin(x_r[N], neg_r[N]);
      sin_r  <= fin(y_r[N], neg_r[N]);
      item_r <= it_r[N];
    end
  end

  assign out_v    = out_v_r;
  assign cos_q    = cos_r;
  assign sin_q    = sin_r;
  assign out_item = item_r;

  `include "axis_angle_vector_rotate_assert.svh"
  `AAVR_ASSERT(a_cos_rng, out_v_r |-> (cos_r <= ONE_Q14 && cos_r >= -ONE_Q14), "cos out of range")
  `AAVR_ASSERT(a_sin_rng, out_v_r |-> (sin_r <= ONE_Q14 && sin_r >= -ONE_Q14), "sin out of range")
endmodule
`default_nettype wire
